// ----- rtl/core/pcdf_pkg.sv -----
`timescale 1ns / 1ps
package pcdf_pkg;

  localparam int CNT_W      = 16;            // capture counter width
  localparam int PER_W      = CNT_W + 1;     // high + low without wrap
  localparam int CLK_W      = 24;            // timer clock register width
  localparam int DUTY_W     = 7;
  localparam int SCALED_W   = CNT_W + DUTY_W;
  localparam int DIV_STEPS  = CLK_W;         // one quotient bit per cycle
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [CLK_W-1:0]  CLK_RESET = CLK_W'(8000000);
  localparam logic [DUTY_W-1:0] PCT_SCALE = DUTY_W'(100);

  // job handed from the capture front end to the arithmetic back end
  typedef struct packed {
    logic             calc;              // period complete, divide
    logic             next_edge_rising;
    logic             measuring;
    logic [CNT_W-1:0] high;
    logic [PER_W-1:0] period;
  } pcdf_job_t;

endpackage

// ----- rtl/core/pcdf_if.sv -----
`timescale 1ns / 1ps
interface pcdf_in_if
  import pcdf_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [CNT_W-1:0] capture_time;

  modport source (output valid, output kind, output capture_time, input ready);
  modport sink   (input valid, input kind, input capture_time, output ready);
endinterface

interface pcdf_out_if
  import pcdf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              next_edge_rising;
  logic              measuring;
  logic              result_valid;
  logic              zero_period;
  logic [DUTY_W-1:0] duty_percent;
  logic [CLK_W-1:0]  frequency_hz;

  modport source (output valid, output next_edge_rising, output measuring,
                  output result_valid, output zero_period, output duty_percent,
                  output frequency_hz, input ready);
  modport sink   (input valid, input next_edge_rising, input measuring,
                  input result_valid, input zero_period, input duty_percent,
                  input frequency_hz, output ready);
endinterface

// ----- rtl/core/pwm_capture_duty_frequency.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// in_chan   in   valid / ready    kind, capture_time
// out_chan  out  valid / ready    next_edge_rising, measuring, result_valid,
//                                 zero_period, duty_percent, frequency_hz
// cfg_*     in   cfg_we           cfg_wdata = timer_clock_hz
//
// Start and the first two captures pass through the job queue and the output
// register. The period-closing capture also runs through the restoring
// dividers (one quotient bit per cycle for duty and frequency in parallel).
// The front end keeps accepting into a 2-entry job queue while the back end
// divides; a stalled output holds its register and backs up the queue.
// Synchronous active-low reset; no clearing pass.
module pwm_capture_duty_frequency
  import pcdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  pcdf_in_if.sink          in_chan,
  pcdf_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [CLK_W-1:0] cfg_wdata
);

  logic [CLK_W-1:0] clk_hz_r;
  logic             fj_valid, fj_ready, bj_valid, bj_ready;
  pcdf_job_t        fj, bj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (cfg_we) begin
      clk_hz_r <= cfg_wdata;
    end
  end

  pcdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  pcdf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  (fj),
    .rd_valid (bj_valid),
    .rd_ready (bj_ready),
    .rd_data  (bj)
  );

  pcdf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .timer_clock_hz (clk_hz_r),
    .job_valid      (bj_valid),
    .job_ready      (bj_ready),
    .job            (bj),
    .out_chan       (out_chan)
  );

  a_done_not_measuring: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.result_valid |-> !out_chan.measuring)
    else $error("completed measurement flagged as still measuring");

  a_zero_period_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.zero_period |->
      out_chan.duty_percent == '0 && out_chan.frequency_hz == '0)
    else $error("zero period with nonzero results");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.duty_percent <= PCT_SCALE)
    else $error("duty above full scale");

  a_calc_job_complete: assert property (@(posedge clk) disable iff (!rst_n)
    fj_valid && fj_ready && fj.calc |-> !fj.measuring && fj.next_edge_rising)
    else $error("period job with wrong edge or measuring flag");

endmodule

// ----- rtl/core/pcdf_front.sv -----
`timescale 1ns / 1ps
module pcdf_front
  import pcdf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  pcdf_in_if.sink   in_chan,
  output logic      job_valid,
  input  logic      job_ready,
  output pcdf_job_t job
);

  typedef enum logic [3:0] {
    PH_RISE1 = 4'b0001,
    PH_FALL  = 4'b0010,
    PH_RISE2 = 4'b0100,
    PH_IDLE  = 4'b1000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] rise_r, rise_nxt;
  logic [CNT_W-1:0] fall_r, fall_nxt;
  logic [CNT_W-1:0] high, low;
  logic             accept;

  assign in_chan.ready = job_ready;
  assign job_valid     = in_chan.valid;
  assign accept        = in_chan.valid & job_ready;

  // modular differences of the counter
  assign high = fall_r - rise_r;
  assign low  = in_chan.capture_time - fall_r;

  always_comb begin
    phase_nxt            = phase_r;
    rise_nxt             = rise_r;
    fall_nxt             = fall_r;
    job.calc             = 1'b0;
    job.next_edge_rising = 1'b1;
    job.measuring        = 1'b0;
    job.high             = high;
    job.period           = {1'b0, high} + {1'b0, low};
    if (!in_chan.kind) begin
      phase_nxt     = PH_RISE1;
      job.measuring = 1'b1;
    end else begin
      case (phase_r)
        PH_RISE1: begin
          rise_nxt             = in_chan.capture_time;
          phase_nxt            = PH_FALL;
          job.next_edge_rising = 1'b0;
          job.measuring        = 1'b1;
        end
        PH_FALL: begin
          fall_nxt      = in_chan.capture_time;
          phase_nxt     = PH_RISE2;
          job.measuring = 1'b1;
        end
        PH_RISE2: begin
          phase_nxt = PH_IDLE;
          job.calc  = 1'b1;
        end
        default: begin
          // capture while not armed changes no state and gives a job without a result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rise_r  <= '0;
      fall_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
    end
  end

endmodule

// ----- rtl/core/pcdf_fifo.sv -----
`timescale 1ns / 1ps
module pcdf_fifo
  import pcdf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  pcdf_job_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output pcdf_job_t rd_data
);

  pcdf_job_t         mem [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != FCNT_W'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/pcdf_back.sv -----
`timescale 1ns / 1ps
module pcdf_back
  import pcdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CLK_W-1:0] timer_clock_hz,
  input  logic             job_valid,
  output logic             job_ready,
  input  pcdf_job_t        job,
  pcdf_out_if.source       out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PER_W-1:0]  period_r, period_nxt;
  // two restoring dividers run side by side: duty and frequency
  logic [CLK_W-1:0]  qd_r, qd_nxt, qf_r, qf_nxt;
  logic [PER_W-1:0]  rd_r, rd_nxt, rf_r, rf_nxt;
  logic [PER_W:0]    td, tf, thr;
  logic              ged, gef;
  logic [SCALED_W-1:0] scaled;
  logic [DUTY_W:0]   duty_sum;
  logic [DUTY_W-1:0] duty;
  logic              out_free, take;

  logic              ov_r, ov_nxt;
  logic              o_rise_r, o_rise_nxt, o_meas_r, o_meas_nxt;
  logic              o_res_r, o_res_nxt, o_zero_r, o_zero_nxt;
  logic [DUTY_W-1:0] o_duty_r, o_duty_nxt;
  logic [CLK_W-1:0]  o_freq_r, o_freq_nxt;

  assign out_free  = !ov_r || out_chan.ready;
  assign job_ready = (state_r == ST_IDLE) && (job.calc || out_free);
  assign take      = job_valid && job_ready;
  assign scaled    = job.high * PCT_SCALE;

  assign td  = {rd_r, qd_r[CLK_W-1]};
  assign tf  = {rf_r, qf_r[CLK_W-1]};
  assign ged = (td >= {1'b0, period_r});
  assign gef = (tf >= {1'b0, period_r});

  // round up when remainder >= period/2 + period/8, clip at full scale
  assign thr      = {2'b00, period_r[PER_W-1:1]} + {4'b0000, period_r[PER_W-1:3]};
  assign duty_sum = {1'b0, qd_r[DUTY_W-1:0]} + {{DUTY_W{1'b0}}, ({1'b0, rd_r} >= thr)};
  assign duty     = (duty_sum > {1'b0, PCT_SCALE}) ? PCT_SCALE : duty_sum[DUTY_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    period_nxt = period_r;
    qd_nxt     = qd_r;
    qf_nxt     = qf_r;
    rd_nxt     = rd_r;
    rf_nxt     = rf_r;
    ov_nxt     = ov_r && !out_chan.ready;
    o_rise_nxt = o_rise_r;
    o_meas_nxt = o_meas_r;
    o_res_nxt  = o_res_r;
    o_zero_nxt = o_zero_r;
    o_duty_nxt = o_duty_r;
    o_freq_nxt = o_freq_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (job.calc) begin
            period_nxt = job.period;
            qd_nxt     = CLK_W'(scaled);
            qf_nxt     = timer_clock_hz;
            rd_nxt     = '0;
            rf_nxt     = '0;
            step_nxt   = '0;
            state_nxt  = ST_DIV;
          end else begin
            ov_nxt     = 1'b1;
            o_rise_nxt = job.next_edge_rising;
            o_meas_nxt = job.measuring;
            o_res_nxt  = 1'b0;
            o_zero_nxt = 1'b0;
            o_duty_nxt = '0;
            o_freq_nxt = '0;
          end
        end
      end
      ST_DIV: begin
        qd_nxt   = {qd_r[CLK_W-2:0], ged};
        qf_nxt   = {qf_r[CLK_W-2:0], gef};
        rd_nxt   = ged ? PER_W'(td - {1'b0, period_r}) : td[PER_W-1:0];
        rf_nxt   = gef ? PER_W'(tf - {1'b0, period_r}) : tf[PER_W-1:0];
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_rise_nxt = 1'b1;
          o_meas_nxt = 1'b0;
          o_res_nxt  = 1'b1;
          if (period_r == '0) begin
            o_zero_nxt = 1'b1;
            o_duty_nxt = '0;
            o_freq_nxt = '0;
          end else begin
            o_zero_nxt = 1'b0;
            o_duty_nxt = duty;
            o_freq_nxt = qf_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    period_r <= period_nxt;
    qd_r     <= qd_nxt;
    qf_r     <= qf_nxt;
    rd_r     <= rd_nxt;
    rf_r     <= rf_nxt;
    o_rise_r <= o_rise_nxt;
    o_meas_r <= o_meas_nxt;
    o_res_r  <= o_res_nxt;
    o_zero_r <= o_zero_nxt;
    o_duty_r <= o_duty_nxt;
    o_freq_r <= o_freq_nxt;
  end

  assign out_chan.valid            = ov_r;
  assign out_chan.next_edge_rising = o_rise_r;
  assign out_chan.measuring        = o_meas_r;
  assign out_chan.result_valid     = o_res_r;
  assign out_chan.zero_period      = o_zero_r;
  assign out_chan.duty_percent     = o_duty_r;
  assign out_chan.frequency_hz     = o_freq_r;

endmodule
